// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl files
// no dependencies; clock is clk, reset is rst_n (active low)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on clk, off while reset is held
`define HRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication sampled on clk, off while reset is held
`define HRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/hrs_pkg.sv -----
// shared constants for the heartbeat reset supervisor
// no dependencies
package hrs_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 4;
  localparam int OUT_W     = 4;
  localparam int BLINK_W   = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_FAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PAUSE = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] HB_TIMEOUT_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] GRACE_RST       = 16'd30000;
  localparam logic [CFG_W-1:0] PULSE_LEN_RST   = 16'd500;
  localparam logic [CFG_W-1:0] BLINK_FAST_RST  = 16'd200;
  localparam logic [CFG_W-1:0] BLINK_PAUSE_RST = 16'd1000;

endpackage

// ----- src/heartbeat_reset_supervisor_top.sv -----
// Path: an accepted item passes the input register, then the result register.
// Throughput: one tick item per cycle unless stalled; all channel counters update in one pass.
// Reset: synchronous, active low; counters, line and indicator state and config registers take
// their reset values in the reset cycle, no clearing pass; the payload registers have no reset.
// Uses hrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module heartbeat_reset_supervisor_top #(
  parameter int CHANNELS   = hrs_pkg::CHANNELS_DEF,
  parameter int TIMER_BITS = hrs_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hrs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hrs_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hrs_pkg::IN_W-1:0]      in_heartbeat_edges,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hrs_pkg::OUT_W-1:0]     out_reset_lines,
  output logic [hrs_pkg::OUT_W-1:0]     out_error_bits,
  output logic                          out_green_led,
  output logic                          out_red_led
);

  localparam int CW = hrs_pkg::CFG_W;
  localparam int WB = (TIMER_BITS > CW) ? TIMER_BITS : CW;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam int BW = hrs_pkg::BLINK_W;

  typedef logic [TIMER_BITS-1:0] tmr_t;

  // register value saturated into the counter width
  function automatic tmr_t fit_f(input logic [CW-1:0] v);
    logic [WB-1:0] ext;
    ext = WB'(v);
    if (ext > WB'(TMAX)) return TMAX;
    else return ext[TIMER_BITS-1:0];
  endfunction

  function automatic tmr_t down_f(input tmr_t v);
    return (v != '0) ? v - tmr_t'(1) : '0;
  endfunction

  // configuration, stored already saturated
  tmr_t hb_timeout_r, grace_r, pulse_len_r, blink_fast_r, blink_pause_r;

  // input stage and handshake
  logic                    in_valid_r;
  logic [hrs_pkg::IN_W-1:0] in_edges_r;
  logic                    out_valid_r;
  logic                    adv;
  logic                    in_take;

  // supervisor state
  tmr_t                watch_r [CHANNELS];
  tmr_t                pulse_r [CHANNELS];
  logic [CHANNELS-1:0] rel_r;
  logic [CHANNELS-1:0] fault_r;
  tmr_t                blink_r;
  logic [BW-1:0]       cnt_r;
  logic                green_r;
  logic                red_r;

  tmr_t                watch_nxt [CHANNELS];
  tmr_t                pulse_nxt [CHANNELS];
  logic [CHANNELS-1:0] rel_nxt;
  logic [CHANNELS-1:0] fault_nxt;
  tmr_t                blink_nxt;
  logic [BW-1:0]       cnt_nxt;
  logic                green_nxt;
  logic                red_nxt;
  logic [CHANNELS-1:0] edge_v;
  logic [BW-1:0]       target;

  // result register
  logic [hrs_pkg::OUT_W-1:0] lines_r, errs_r;
  logic                      green_out_r, red_out_r;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign edge_v   = CHANNELS'(in_edges_r);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      watch_nxt[c] = down_f(watch_r[c]);
      pulse_nxt[c] = down_f(pulse_r[c]);
      rel_nxt[c]   = rel_r[c];
      fault_nxt[c] = fault_r[c];
      if (edge_v[c]) begin
        watch_nxt[c] = hb_timeout_r;
        fault_nxt[c] = 1'b0;
      end
      if (rel_r[c]) begin
        if (watch_nxt[c] == '0) begin
          rel_nxt[c]   = 1'b0;
          pulse_nxt[c] = pulse_len_r;
          watch_nxt[c] = grace_r;
          fault_nxt[c] = 1'b1;
        end
      end else if (pulse_nxt[c] == '0) begin
        rel_nxt[c] = 1'b1;
      end
    end
  end

  // lowest failing channel plus one
  always_comb begin
    target = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (fault_nxt[c]) target = BW'(c + 1);
    end
  end

  always_comb begin
    blink_nxt = down_f(blink_r);
    cnt_nxt   = cnt_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    if (blink_nxt == '0) begin
      if (fault_nxt == '0) begin
        red_nxt   = 1'b0;
        green_nxt = !green_r;
        blink_nxt = blink_fast_r;
        cnt_nxt   = '0;
      end else begin
        green_nxt = 1'b0;
        if (red_r) cnt_nxt = cnt_r + BW'(1);
        red_nxt = !red_r;
        if (cnt_nxt >= target) begin
          cnt_nxt   = '0;
          blink_nxt = blink_pause_r;
        end else begin
          blink_nxt = blink_fast_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_timeout_r  <= fit_f(hrs_pkg::HB_TIMEOUT_RST);
      grace_r       <= fit_f(hrs_pkg::GRACE_RST);
      pulse_len_r   <= fit_f(hrs_pkg::PULSE_LEN_RST);
      blink_fast_r  <= fit_f(hrs_pkg::BLINK_FAST_RST);
      blink_pause_r <= fit_f(hrs_pkg::BLINK_PAUSE_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hrs_pkg::REG_HB_TIMEOUT:  hb_timeout_r  <= fit_f(cfg_wdata);
        hrs_pkg::REG_GRACE:       grace_r       <= fit_f(cfg_wdata);
        hrs_pkg::REG_PULSE_LEN:   pulse_len_r   <= fit_f(cfg_wdata);
        hrs_pkg::REG_BLINK_FAST:  blink_fast_r  <= fit_f(cfg_wdata);
        hrs_pkg::REG_BLINK_PAUSE: blink_pause_r <= fit_f(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        watch_r[c] <= fit_f(hrs_pkg::GRACE_RST);
        pulse_r[c] <= '0;
      end
      rel_r   <= '1;
      fault_r <= '0;
      blink_r <= '0;
      cnt_r   <= '0;
      green_r <= 1'b1;
      red_r   <= 1'b0;
    end else begin
      if (in_take) in_valid_r <= 1'b1;
      else if (adv) in_valid_r <= 1'b0;
      if (adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (adv) begin
        for (int c = 0; c < CHANNELS; c++) begin
          watch_r[c] <= watch_nxt[c];
          pulse_r[c] <= pulse_nxt[c];
        end
        rel_r   <= rel_nxt;
        fault_r <= fault_nxt;
        blink_r <= blink_nxt;
        cnt_r   <= cnt_nxt;
        green_r <= green_nxt;
        red_r   <= red_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) in_edges_r <= in_heartbeat_edges;
    if (adv) begin
      lines_r     <= hrs_pkg::OUT_W'(rel_nxt);
      errs_r      <= hrs_pkg::OUT_W'(fault_nxt);
      green_out_r <= green_nxt;
      red_out_r   <= red_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reset_lines = lines_r;
  assign out_error_bits  = errs_r;
  assign out_green_led   = green_out_r;
  assign out_red_led     = red_out_r;

  `HRS_ASSERT(a_leds_exclusive, !(green_r && red_r), "green and red lit together")
  `HRS_ASSERT(a_drop_sets_fault, ((~rel_r & $past(rel_r) & ~fault_r) == '0),
    "reset line dropped without error bit")
  `HRS_ASSERT_NEXT(a_state_holds, !adv, $stable(fault_r) && $stable(rel_r),
    "state changed without an item")
  `HRS_ASSERT(a_result_has_item, $rose(out_valid_r) |-> $past(in_valid_r), "result without item")

endmodule
